// ----- design/modular_exponentiation_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros shared by the modular exponentiation design files
// Each macro wraps one concurrent assertion on the rising clock edge, with
// the checks switched off while the synchronous reset is held.
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_TOP_MACROS_SVH
`define MODULAR_EXPONENTIATION_TOP_MACROS_SVH

// Same-cycle implication
`define MEXP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define MEXP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/mexp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared constants for the modular exponentiation block: field widths and
// configuration register indexes.
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int DATA_W     = 32;  // base, result and register words on the ports
  localparam int CFG_ADDR_W = 1;

  localparam logic [CFG_ADDR_W-1:0] CFG_EXPONENT = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MODULUS  = 1'd1;

endpackage

// ----- design/mexp_mulmod.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_mulmod
// Bit-serial interleaved modular multiplier: r = (x * y) mod m, taking one
// bit of y per cycle from the top. Needs x < m; y may be any word. A modulus
// of 2^WORD_BITS is given as m_ext with its top bit set.
// ----------------------------------------------------------------------------
`include "modular_exponentiation_top_macros.svh"

module mexp_mulmod #(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [WORD_BITS-1:0] x,
  input  logic [WORD_BITS-1:0] y,
  input  logic [WORD_BITS:0]   m_ext,
  output logic                 done,
  output logic [WORD_BITS-1:0] result
);

  localparam int CNT_W = $clog2(WORD_BITS);
  localparam int T_W   = WORD_BITS + 3;

  logic [WORD_BITS-1:0] x_r;
  logic [WORD_BITS-1:0] y_r;
  logic [WORD_BITS-1:0] r_r;
  logic [WORD_BITS-1:0] r_nxt;
  logic [CNT_W-1:0]     cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [T_W-1:0]       t;
  logic [T_W-1:0]       d1;
  logic [T_W-1:0]       d2;

  // 2r + bit*x stays below 3m, so at most two subtractions of m
  always_comb begin
    t  = T_W'({r_r, 1'b0}) + (y_r[WORD_BITS-1] ? T_W'(x_r) : '0);
    d1 = t - T_W'(m_ext);
    d2 = t - T_W'({m_ext, 1'b0});
    if (!d2[T_W-1]) begin
      r_nxt = d2[WORD_BITS-1:0];
    end else if (!d1[T_W-1]) begin
      r_nxt = d1[WORD_BITS-1:0];
    end else begin
      r_nxt = t[WORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(WORD_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= x;
      y_r <= y;
      r_r <= '0;
    end else if (busy_r) begin
      y_r <= {y_r[WORD_BITS-2:0], 1'b0};
      r_r <= r_nxt;
    end
  end

  assign done   = done_r;
  assign result = r_r;

  `MEXP_ASSERT_NOW(a_start_when_free, clk, rst_n, start, !busy_r, "mulmod started while busy")
  `MEXP_ASSERT_NOW(a_done_not_busy, clk, rst_n, done_r, !busy_r, "mulmod done while still busy")
  `MEXP_ASSERT_NOW(a_result_reduced, clk, rst_n, done_r, ({1'b0, r_r} < m_ext), "mulmod result not reduced")

endmodule

// ----- design/modular_exponentiation_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation_top
// Raises each incoming word to the configured exponent modulo the configured
// modulus, scanning the exponent from its lowest bit (square and multiply).
// ----------------------------------------------------------------------------
//   channel  direction  payload
//   in_      slave      tdata = base, tlast = last_symbol
//   out_     master     tdata = power_result, tlast = last_result
//   cfg_     write      index 0 exponent, index 1 modulus
//
// Every modular multiplication runs in the bit-serial multiplier, which is
// the only arithmetic unit and is shared by all steps.
// An item costs one base reduction, a multiply per set exponent bit and a
// square per bit below the highest set one; a zero exponent skips all of
// them and goes straight to the output register.
// Synchronous active-low reset; no clearing pass.
// A new item is taken once the previous result sits in the output register.
// ----------------------------------------------------------------------------
`include "modular_exponentiation_top_macros.svh"

module modular_exponentiation_top
  import mexp_pkg::*;
#(
  parameter int WORD_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [DATA_W-1:0]     in_tdata,   // [31:0] base
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [DATA_W-1:0]     out_tdata,  // [31:0] power_result
  output logic                  out_tlast,
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [DATA_W-1:0]     cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED,
    S_MUL,
    S_SQR,
    S_OUT
  } state_t;

  state_t               state_r;
  logic [WORD_BITS-1:0] exp_r;
  logic [WORD_BITS-1:0] mod_r;
  logic [WORD_BITS:0]   mod_ext;
  logic [WORD_BITS-1:0] e_sh_r;
  logic [WORD_BITS-1:0] acc_r;
  logic [WORD_BITS-1:0] pw_r;
  logic                 last_r;
  logic                 mul_start_r;
  logic [WORD_BITS-1:0] mul_x_r;
  logic [WORD_BITS-1:0] mul_y_r;
  logic                 mul_done;
  logic [WORD_BITS-1:0] mul_res;
  logic                 out_valid_r;
  logic [WORD_BITS-1:0] out_data_r;
  logic                 out_last_r;

  // modulus 0 stands for 2^WORD_BITS
  assign mod_ext = {(mod_r == '0), mod_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r <= '0;
      mod_r <= WORD_BITS'(1);
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_EXPONENT: exp_r <= cfg_wdata[WORD_BITS-1:0];
        CFG_MODULUS:  mod_r <= cfg_wdata[WORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  mexp_mulmod #(
    .WORD_BITS(WORD_BITS)
  ) u_mulmod (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start_r),
    .x      (mul_x_r),
    .y      (mul_y_r),
    .m_ext  (mod_ext),
    .done   (mul_done),
    .result (mul_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mul_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mul_start_r <= 1'b0;
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            last_r <= in_tlast;
            acc_r  <= WORD_BITS'(1);
            e_sh_r <= exp_r;
            if (exp_r == '0) begin
              state_r <= S_OUT;
            end else begin
              // reduce the base first: (1 mod m) * base
              mul_x_r     <= (mod_r == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
              mul_y_r     <= in_tdata[WORD_BITS-1:0];
              mul_start_r <= 1'b1;
              state_r     <= S_RED;
            end
          end
        end
        S_RED: begin
          if (mul_done) begin
            pw_r        <= mul_res;
            mul_x_r     <= mul_res;
            mul_y_r     <= e_sh_r[0] ? acc_r : mul_res;
            mul_start_r <= 1'b1;
            state_r     <= e_sh_r[0] ? S_MUL : S_SQR;
          end
        end
        S_MUL: begin
          if (mul_done) begin
            acc_r <= mul_res;
            // skip the square once no higher bit is left
            if (e_sh_r[WORD_BITS-1:1] == '0) begin
              state_r <= S_OUT;
            end else begin
              mul_x_r     <= pw_r;
              mul_y_r     <= pw_r;
              mul_start_r <= 1'b1;
              state_r     <= S_SQR;
            end
          end
        end
        S_SQR: begin
          if (mul_done) begin
            pw_r        <= mul_res;
            e_sh_r      <= {1'b0, e_sh_r[WORD_BITS-1:1]};
            mul_x_r     <= mul_res;
            mul_y_r     <= e_sh_r[1] ? acc_r : mul_res;
            mul_start_r <= 1'b1;
            state_r     <= e_sh_r[1] ? S_MUL : S_SQR;
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= acc_r;
            out_last_r  <= last_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = DATA_W'(out_data_r);
  assign out_tlast  = out_last_r;

  `MEXP_ASSERT_NOW(a_done_in_work, clk, rst_n, mul_done, (state_r == S_RED || state_r == S_MUL || state_r == S_SQR), "multiplier finished outside a work state")
  `MEXP_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, (in_tvalid && in_tready), (state_r != S_IDLE), "transfer accepted but block stayed idle")
  `MEXP_ASSERT_NEXT(a_out_loaded, clk, rst_n, (state_r == S_OUT && !out_valid_r), out_valid_r, "finished result not loaded into free output register")
  `MEXP_ASSERT_NOW(a_mul_bits_left, clk, rst_n, (state_r == S_SQR && mul_start_r), (e_sh_r[WORD_BITS-1:1] != '0), "square issued with no exponent bits left")

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation testbench
// Streams words through the block under a series of exponent and modulus
// settings, predicts base^exponent mod modulus for every accepted word, and
// compares each result word and its last marker in order. Both stream sides
// idle at random in bursts, except in the closing stretch.
// ----------------------------------------------------------------------------
module testbench
  import mexp_pkg::*;
();

  localparam int          WORD_BITS  = 32;
  localparam int          HALF_CLK   = 6;
  localparam int unsigned CYCLE_CAP  = 4_000_000;
  localparam int          MSG_WORDS  = 273;
  localparam int          CALM_WORDS = 40;
  localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0] power;
    logic        last;
  } power_word_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [DATA_W-1:0]     in_tdata;   // [31:0] base
  logic                  in_tlast;   // last_symbol
  logic                  out_tvalid;
  logic                  out_tready;
  logic [DATA_W-1:0]     out_tdata;  // [31:0] power_result
  logic                  out_tlast;  // last_result
  logic                  cfg_wr_en;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [DATA_W-1:0]     cfg_wdata;

  power_word_t pending_powers[$];
  logic [31:0] key_exponent;
  logic [31:0] key_modulus;
  bit          jitter_on;
  int          mismatches;
  int          words_sent;
  int          results_seen;
  int          key_settings;
  int unsigned cycle_count;

  modular_exponentiation_top #(
    .WORD_BITS(WORD_BITS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #HALF_CLK clk = 1'b1;
    #HALF_CLK clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Product of two words reduced by the modulus; a zero modulus wraps instead.
  function automatic logic [63:0] mul_reduce(logic [63:0] x, logic [63:0] y,
                                             logic [31:0] n);
    logic [63:0] prod;
    prod = x * y;
    if (n == 0) return {32'd0, prod[31:0]};
    return prod % {32'd0, n};
  endfunction

  // Right-to-left square and multiply over the exponent bits.
  function automatic logic [31:0] mod_power(logic [31:0] b, logic [31:0] e,
                                            logic [31:0] n);
    logic [63:0] acc;
    logic [63:0] sq;
    if (e == 0) return 32'd1;
    acc = 64'd1;
    sq  = {32'd0, b};
    for (int i = 0; i < WORD_BITS; i++) begin
      if (e[i]) acc = mul_reduce(acc, sq, n);
      sq = mul_reduce(sq, sq, n);
    end
    return acc[31:0];
  endfunction

  // Offer one word, hold it until the transfer, then log the expected power.
  task automatic send_word(input logic [31:0] base, input logic last);
    power_word_t exp_word;
    if (jitter_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= base;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    exp_word.power = mod_power(base, key_exponent, key_modulus);
    exp_word.last  = last;
    pending_powers.push_back(exp_word);
    words_sent++;
  endtask

  // Drop valid and wait for every outstanding result.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_powers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_keys(input logic [31:0] exponent, input logic [31:0] modulus);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_addr  <= CFG_EXPONENT;
    cfg_wdata <= exponent;
    @(posedge clk);
    cfg_addr  <= CFG_MODULUS;
    cfg_wdata <= modulus;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    key_exponent = exponent;
    key_modulus  = modulus;
    key_settings++;
  endtask

  function automatic logic [31:0] pick_exponent();
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return 32'd1;
      2:       return ALL_ONES;
      3:       return 32'd1 << $urandom_range(0, 31);
      4, 5:    return $urandom;
      default: return $urandom_range(2, 65535);
    endcase
  endfunction

  function automatic logic [31:0] pick_modulus();
    case ($urandom_range(0, 6))
      0:       return 32'd1;
      1:       return ALL_ONES;
      2:       return $urandom_range(2, 255);
      3:       return $urandom_range(256, 65535);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_base(logic [31:0] n);
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return ALL_ONES;
      2:       return (n == 0) ? $urandom : ($urandom % n);
      default: return $urandom;
    endcase
  endfunction

  // Out of reset the exponent is zero, so every word must come back as one.
  task automatic test_reset_keys();
    key_exponent = 32'd0;
    key_modulus  = 32'd1;
    send_word(32'd0, 1'b0);
    send_word(ALL_ONES, 1'b1);
    send_word(32'd5, 1'b0);
  endtask

  task automatic test_extremes();
    set_keys(ALL_ONES, ALL_ONES);
    send_word(32'd0, 1'b0);
    send_word(32'd1, 1'b0);
    send_word(ALL_ONES - 1, 1'b0);
    send_word(ALL_ONES, 1'b0);       // base equal to the modulus
    send_word($urandom, 1'b1);
    set_keys(32'd1, 32'd1);          // unit modulus with a live exponent
    send_word(32'd9, 1'b0);
    send_word(ALL_ONES, 1'b1);
    set_keys(32'h8000_0000, 32'd0);  // zero modulus: products wrap
    send_word(32'd3, 1'b0);
    send_word(32'hDEAD_BEEF, 1'b1);
    set_keys(32'd17, 32'd3233);
    send_word(32'd65, 1'b0);
    send_word(32'd3232, 1'b0);
    send_word(32'd3233, 1'b0);
    send_word(32'hDEAD_BEEF, 1'b1);  // base far above the modulus
    set_keys(32'd0, ALL_ONES);
    send_word(32'd7, 1'b1);
  endtask

  // Messages of random length, each under freshly chosen keys.
  task automatic test_messages(input int word_count);
    int done;
    int msg_len;
    done = 0;
    while (done < word_count) begin
      set_keys(pick_exponent(), pick_modulus());
      msg_len = $urandom_range(3, 30);
      if (msg_len > word_count - done) msg_len = word_count - done;
      for (int k = 0; k < msg_len; k++)
        send_word(pick_base(key_modulus), (k == msg_len - 1) ? 1'b1 : 1'($urandom));
      done += msg_len;
    end
  endtask

  initial begin
    forever begin
      if (jitter_on && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    power_word_t exp_word;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_powers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: power %h last %b", out_tdata, out_tlast);
      end else begin
        exp_word = pending_powers.pop_front();
        if (out_tdata !== exp_word.power || out_tlast !== exp_word.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected power %h last %b, got power %h last %b",
                     results_seen, exp_word.power, exp_word.last, out_tdata, out_tlast);
        end
      end
    end
  end

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tlast     = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_addr     = CFG_EXPONENT;
    cfg_wdata    = '0;
    cycle_count  = 0;
    mismatches   = 0;
    words_sent   = 0;
    results_seen = 0;
    key_settings = 0;
    jitter_on    = 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_keys();
    test_extremes();
    test_messages(MSG_WORDS - CALM_WORDS);
    jitter_on = 1'b0;
    test_messages(CALM_WORDS);
    settle();
    repeat (20) @(posedge clk);

    $display("%0d words raised under %0d key settings, %0d results compared",
             words_sent, key_settings, results_seen);
    $display("%0d mismatches, %0d results still outstanding",
             mismatches, pending_powers.size());
    if (mismatches == 0 && pending_powers.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
